/* rtl/ccfr_pkg.sv */
// Shared types, constants and helper functions of the COBS/CRC frame receiver.
// Depends on nothing; every other file of the block but ccfr_state_ram imports it.
package ccfr_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_ENCODED_DEF = 512;
  localparam int unsigned NUM_LINKS_DEF   = 2;

  // Per-link state holds two counters plus 66 bits of fixed-width fields
  localparam int unsigned LANE_FIXED_W = 66;

  // Frame format and CRC-16/CCITT-FALSE constants
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  DELIM     = 8'h00;
  localparam logic [7:0]  BLOCK_MAX = 8'hFF;
  localparam int unsigned MIN_FRAME = 6;
  localparam int unsigned PAY_CNT_W = 9;

  // Verdict status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_CRC   = 3'd2,
    ST_TRUNC = 3'd3,
    ST_OVF   = 3'd4
  } status_e;

  // Input request: one encoded byte tagged with its link
  typedef struct packed {
    logic       link;
    logic [7:0] rx_byte;
  } in_req_t;

  // Output request: payload byte or end-of-frame verdict
  typedef struct packed {
    logic                 out_link;
    logic                 is_verdict;
    logic [7:0]           payload_byte;
    status_e              status;
    logic [7:0]           seq_number;
    logic [15:0]          command_word;
    logic [PAY_CNT_W-1:0] payload_count;
  } out_rsp_t;

  // One byte of CRC-16, MSB first, no reflection
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Assemble a 16-bit word from two bytes in frame order
  function automatic logic [15:0] make_word(input logic [7:0] first, input logic [7:0] second,
                                            input logic big_endian);
    return big_endian ? {first, second} : {second, first};
  endfunction

endpackage

/* rtl/ccfr_state_ram.sv */
// Per-link state memory: one write port, one registered read port, valid bits.
// Depends on nothing from the package; width and depth come from parameters.
module ccfr_state_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 86,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o,
  output logic             rd_init_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] written_q;
  logic [Width-1:0] rd_data_q;
  logic             rd_init_q;

  // Storage array and read data, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Written flags: an entry never written reads as the reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_init_q <= 1'b1;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_init_q <= !written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_init_o = rd_init_q;

endmodule

/* rtl/ccfr_lane_update.sv */
// Per-byte update of one link's COBS decode, CRC and header state.
// Depends on ccfr_pkg for the request types, CRC function and status codes.
module ccfr_lane_update
  import ccfr_pkg::*;
#(
  parameter int unsigned MaxEncoded = MAX_ENCODED_DEF,
  localparam int unsigned CntW = $clog2(MaxEncoded + 1),
  localparam int unsigned StW  = 2 * CntW + LANE_FIXED_W
) (
  input  logic [StW-1:0] cur_i,
  input  logic           fresh_i,
  input  logic           link_i,
  input  logic [7:0]     byte_i,
  input  logic           big_endian_i,
  output logic [StW-1:0] nxt_o,
  output logic           res_valid_o,
  output out_rsp_t       res_o
);

  typedef struct packed {
    logic [CntW-1:0] enc;
    logic            ovf;
    logic [7:0]      blk_left;
    logic            zero_pend;
    logic [CntW-1:0] dec;
    logic [15:0]     crc;
    logic [15:0]     held;
    logic [23:0]     hdr;
  } lane_t;

  lane_t           init_st;
  lane_t           cur;
  lane_t           nxt;
  logic            have_d;
  logic [7:0]      dbyte;
  logic [CntW-1:0] pay_n;
  status_e         status;

  // Reset value of a lane
  always_comb begin
    init_st     = '0;
    init_st.crc = CRC_INIT;
  end

  assign cur = fresh_i ? init_st : lane_t'(cur_i);

  // Verdict fields from the state at the delimiter
  always_comb begin
    if (cur.ovf) begin
      status = ST_OVF;
    end else if (cur.blk_left != 8'd0) begin
      status = ST_TRUNC;
    end else if (cur.dec < CntW'(MIN_FRAME)) begin
      status = ST_SHORT;
    end else if (cur.crc != make_word(cur.held[15:8], cur.held[7:0], big_endian_i)) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
    pay_n = (cur.dec >= CntW'(MIN_FRAME)) ? cur.dec - CntW'(MIN_FRAME) : '0;
  end

  // Next state and result
  always_comb begin
    nxt         = cur;
    res_valid_o = 1'b0;
    res_o       = '0;
    have_d      = 1'b0;
    dbyte       = 8'h00;
    res_o.out_link = link_i;

    if (byte_i == DELIM) begin
      // End of frame: verdict unless nothing arrived
      nxt = init_st;
      if (cur.enc != '0 || cur.ovf) begin
        res_valid_o          = 1'b1;
        res_o.is_verdict     = 1'b1;
        res_o.status         = status;
        res_o.seq_number     = cur.hdr[23:16];
        res_o.command_word   = make_word(cur.hdr[15:8], cur.hdr[7:0], big_endian_i);
        res_o.payload_count  = PAY_CNT_W'(pay_n);
      end
    end else if (cur.enc >= CntW'(MaxEncoded)) begin
      nxt.ovf = 1'b1;
    end else begin
      nxt.enc = cur.enc + CntW'(1);
      if (cur.blk_left == 8'd0) begin
        // Code byte: opens a block, implied zero before it if one is due
        nxt.zero_pend = (byte_i != BLOCK_MAX);
        nxt.blk_left  = byte_i - 8'd1;
        have_d        = cur.zero_pend;
      end else begin
        nxt.blk_left = cur.blk_left - 8'd1;
        dbyte        = byte_i;
        have_d       = 1'b1;
      end
    end

    // Decoded byte: CRC and payload run two bytes behind
    if (have_d) begin
      if (cur.dec >= CntW'(2)) begin
        nxt.crc = crc_byte(cur.crc, cur.held[15:8]);
        if (cur.dec >= CntW'(MIN_FRAME)) begin
          res_valid_o        = 1'b1;
          res_o.payload_byte = cur.held[15:8];
        end
      end
      if (cur.dec == CntW'(1)) begin
        nxt.hdr[23:16] = dbyte;
      end else if (cur.dec == CntW'(2)) begin
        nxt.hdr[15:8] = dbyte;
      end else if (cur.dec == CntW'(3)) begin
        nxt.hdr[7:0] = dbyte;
      end
      nxt.held = {cur.held[7:0], dbyte};
      nxt.dec  = cur.dec + CntW'(1);
    end
  end

  assign nxt_o = nxt;

endmodule

/* rtl/ccfr_out_buf.sv */
// Two-entry output buffer that decouples the update stage from the consumer.
// Depends on ccfr_pkg for the output request type.
module ccfr_out_buf
  import ccfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  out_rsp_t push_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o,
  output logic [1:0] cnt_o,
  output logic     pop_o
);

  out_rsp_t   head_q, head_d;
  out_rsp_t   tail_q, tail_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] pos;

  assign pop = (cnt_q != 2'd0) && out_ready_i;
  assign pos = cnt_q - {1'b0, pop};

  // Shift on pop, write new request at the first free slot
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop};
    if (pop) begin
      head_d = tail_q;
    end
    if (push_i) begin
      if (pos == 2'd0) begin
        head_d = push_data_i;
      end else begin
        tail_d = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_rsp_o   = head_q;
  assign cnt_o       = cnt_q;
  assign pop_o       = pop;

  // Never more than two requests held, and never a push into a full buffer
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer count out of range");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && cnt_q == 2'd2) |-> pop) else $error("push into full output buffer");

endmodule

/* rtl/cobs_crc_frame_receiver.sv */
// COBS frame receiver with CRC-16/CCITT-FALSE check, top level.
// Depends on ccfr_pkg, ccfr_state_ram, ccfr_lane_update and ccfr_out_buf.
//
// Takes one encoded byte per cycle from any link, interleaved freely, and returns
// payload bytes and end-of-frame verdicts on a valid/ready output. The link's state
// is read from the registered state memory at acceptance, then updated and written back
// in the next cycle, with the write forwarded when the following byte is on the same link.
// Results leave through a two-entry buffer, so a new byte is taken every cycle while
// the consumer keeps up. Per-link state needs no clearing pass after reset; a
// per-entry written flag makes an untouched link read as empty. big_endian_q is
// sampled when a verdict is formed.
module cobs_crc_frame_receiver
  import ccfr_pkg::*;
#(
  parameter int unsigned MAX_ENCODED = MAX_ENCODED_DEF,
  parameter int unsigned NUM_LINKS   = NUM_LINKS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned CntW  = $clog2(MAX_ENCODED + 1);
  localparam int unsigned StW   = 2 * CntW + LANE_FIXED_W;
  localparam int unsigned LinkW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;

  logic             big_endian_q;
  logic             in_accept;
  logic             in_range;
  logic [LinkW-1:0] in_idx;

  logic             s1_valid_q;
  logic [LinkW-1:0] s1_idx_q;
  logic             s1_link_q;
  logic [7:0]       s1_byte_q;

  logic             fwd_valid_q;
  logic [LinkW-1:0] fwd_idx_q;
  logic [StW-1:0]   fwd_data_q;
  logic             fwd_hit;

  logic [StW-1:0]   rd_data;
  logic             rd_init;
  logic [StW-1:0]   cur_st;
  logic             cur_fresh;
  logic [StW-1:0]   nxt_st;
  logic             res_valid;
  out_rsp_t         res;
  logic             push;
  logic [1:0]       buf_cnt;
  logic             buf_pop;
  logic [1:0]       occ;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
    end else if (cfg_we_i) begin
      big_endian_q <= cfg_wdata_i;
    end
  end

  // Input side: room for the request in flight plus this one
  assign occ        = buf_cnt + {1'b0, s1_valid_q};
  assign in_ready_o = (occ <= (2'd1 + {1'b0, buf_pop}));
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_range   = (int'(in_req_i.link) < NUM_LINKS);
  assign in_idx     = LinkW'(in_req_i.link);

  // Update stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_accept && in_range;
      fwd_valid_q <= s1_valid_q;
    end
  end

  // Update stage payload and forwarded write data
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_idx_q  <= in_idx;
      s1_link_q <= in_req_i.link;
      s1_byte_q <= in_req_i.rx_byte;
    end
    fwd_idx_q  <= s1_idx_q;
    fwd_data_q <= nxt_st;
  end

  ccfr_state_ram #(
    .Depth (NUM_LINKS),
    .Width (StW)
  ) u_state_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (in_idx),
    .rd_data_o (rd_data),
    .rd_init_o (rd_init),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (nxt_st)
  );

  // Last cycle's write to the same link is newer than the memory read
  assign fwd_hit   = fwd_valid_q && (fwd_idx_q == s1_idx_q);
  assign cur_st    = fwd_hit ? fwd_data_q : rd_data;
  assign cur_fresh = fwd_hit ? 1'b0 : rd_init;

  ccfr_lane_update #(
    .MaxEncoded (MAX_ENCODED)
  ) u_lane_update (
    .cur_i        (cur_st),
    .fresh_i      (cur_fresh),
    .link_i       (s1_link_q),
    .byte_i       (s1_byte_q),
    .big_endian_i (big_endian_q),
    .nxt_o        (nxt_st),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign push = s1_valid_q && res_valid;

  ccfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cnt_o       (buf_cnt),
    .pop_o       (buf_pop)
  );

  // Backpressure only ever comes from a held output request
  a_stall_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o) else $error("input stalled with empty output");
  // A request leaves the update stage tagged with the link it came in on
  a_result_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (res.out_link == s1_link_q)) else $error("result link mismatch");

endmodule

/* verif/tb_cobs_crc_frame_receiver.sv */
// Self-checking testbench for cobs_crc_frame_receiver: COBS frames on two links, CRC verdicts.
// Depends on ccfr_pkg (request/response types, status codes, frame constants) and the RTL top.
`timescale 1ns / 1ps

module tb_cobs_crc_frame_receiver;
  import ccfr_pkg::*;

  localparam int unsigned MAX_ENC = MAX_ENCODED_DEF;

  // Frame shapes produced by the stimulus generator
  localparam int FK_GOOD    = 0;
  localparam int FK_BAD_CRC = 1;
  localparam int FK_TRUNC   = 2;
  localparam int FK_SHORT   = 3;
  localparam int FK_NOISE   = 4;
  localparam int FK_RUN     = 5;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_we_i    = 1'b0;
  logic     cfg_wdata_i = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_rsp_t out_rsp_o;

  cobs_crc_frame_receiver u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Requests waiting to be sent, expected results, per-link staging of encoded bytes
  in_req_t    rx_byte_q[$];
  out_rsp_t   decoded_out_q[$];
  logic [7:0] stage0_q[$];
  logic [7:0] stage1_q[$];
  logic [7:0] frame_dec_q[$];
  logic [7:0] frame_enc_q[$];

  int   items_made  = 0;
  int   error_count = 0;
  bit   steady_flow = 1'b0;
  logic cfg_big_endian = 1'b0;

  // Predictor state, one entry per link
  logic [9:0]  enc_cnt[2];
  logic        ovf_flag[2];
  logic [7:0]  blk_left[2];
  logic        zero_due[2];
  logic [9:0]  dec_cnt[2];
  logic [15:0] crc_acc[2];
  logic [15:0] hold_pair[2];
  logic [23:0] hdr_bytes[2];

  function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [15:0] frame_word(input logic [7:0] first, input logic [7:0] second);
    return cfg_big_endian ? {first, second} : {second, first};
  endfunction

  function automatic string rsp_text(input out_rsp_t r);
    return $sformatf("link=%0d verdict=%0d byte=%02h status=%0d seq=%02h cmd=%04h count=%0d",
                     r.out_link, r.is_verdict, r.payload_byte, r.status, r.seq_number,
                     r.command_word, r.payload_count);
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  task automatic lane_clear(input int l);
    enc_cnt[l]   = '0;
    ovf_flag[l]  = 1'b0;
    blk_left[l]  = '0;
    zero_due[l]  = 1'b0;
    dec_cnt[l]   = '0;
    crc_acc[l]   = CRC_INIT;
    hold_pair[l] = '0;
    hdr_bytes[l] = '0;
  endtask

  // Expected results of one accepted encoded byte
  task automatic cobs_decode_step(input in_req_t r);
    int          l;
    logic [7:0]  b;
    logic [7:0]  d;
    logic [7:0]  old;
    logic [9:0]  k;
    logic [9:0]  cnt;
    logic        have_d;
    out_rsp_t    e;
    l = int'(r.link);
    b = r.rx_byte;
    e = '0;
    e.out_link = r.link;
    if (b == DELIM) begin
      // empty frames vanish silently
      if (enc_cnt[l] != 0 || ovf_flag[l]) begin
        e.is_verdict = 1'b1;
        if (ovf_flag[l]) e.status = ST_OVF;
        else if (blk_left[l] != 0) e.status = ST_TRUNC;
        else if (dec_cnt[l] < MIN_FRAME) e.status = ST_SHORT;
        else if (crc_acc[l] != frame_word(hold_pair[l][15:8], hold_pair[l][7:0]))
          e.status = ST_CRC;
        else e.status = ST_OK;
        e.seq_number   = hdr_bytes[l][23:16];
        e.command_word = frame_word(hdr_bytes[l][15:8], hdr_bytes[l][7:0]);
        cnt = (dec_cnt[l] >= MIN_FRAME) ? 10'(dec_cnt[l] - MIN_FRAME) : '0;
        e.payload_count = cnt[PAY_CNT_W-1:0];
        decoded_out_q.push_back(e);
      end
      lane_clear(l);
    end else if (enc_cnt[l] >= MAX_ENC) begin
      ovf_flag[l] = 1'b1;
    end else begin
      enc_cnt[l]++;
      have_d = 1'b0;
      d = '0;
      if (blk_left[l] == 0) begin
        // code byte: implied zero only between blocks, never after a full block
        have_d = zero_due[l];
        zero_due[l] = (b != BLOCK_MAX);
        blk_left[l] = b - 8'd1;
      end else begin
        blk_left[l]--;
        d = b;
        have_d = 1'b1;
      end
      if (have_d) begin
        k = dec_cnt[l];
        if (k >= 2) begin
          old = hold_pair[l][15:8];
          crc_acc[l] = crc16_ccitt_step(crc_acc[l], old);
          if (k >= MIN_FRAME) begin
            e.payload_byte = old;
            decoded_out_q.push_back(e);
          end
        end
        if (k == 1) hdr_bytes[l][23:16] = d;
        else if (k == 2) hdr_bytes[l][15:8] = d;
        else if (k == 3) hdr_bytes[l][7:0] = d;
        hold_pair[l] = {hold_pair[l][7:0], d};
        dec_cnt[l] = k + 10'd1;
      end
    end
  endtask

  // Short idle mostly, long now and then
  function automatic int stall_len();
    return ($urandom_range(99) < 90) ? $urandom_range(3, 1) : $urandom_range(40, 8);
  endfunction

  // Sender: one request on the wire at a time, held until accepted
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      send_gap   = 0;
    end else begin
      if (in_valid_i && in_ready_o) cobs_decode_step(in_req_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (rx_byte_q.size() != 0) begin
          in_req_i   <= rx_byte_q.pop_front();
          in_valid_i <= 1'b1;
          send_gap   = (steady_flow || $urandom_range(99) < 65) ? 0 : stall_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls plus one long hold-off while plenty is still queued
  int  rsp_seen;
  int  ready_hold;
  bit  long_hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i    <= 1'b0;
      rsp_seen       = 0;
      ready_hold     = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) rsp_seen++;
      if (!long_hold_done && rsp_seen >= 150 && rx_byte_q.size() > 100) begin
        long_hold_done = 1'b1;
        ready_hold     = 300;
      end
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready_i <= 1'b0;
      end else if (!steady_flow && $urandom_range(99) < 20) begin
        ready_hold  = stall_len() - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result checker
  out_rsp_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_out_q.size() == 0) begin
        note_error($sformatf("unexpected result: %s", rsp_text(out_rsp_o)));
      end else begin
        want = decoded_out_q.pop_front();
        if (out_rsp_o.out_link !== want.out_link || out_rsp_o.is_verdict !== want.is_verdict ||
            out_rsp_o.payload_byte !== want.payload_byte || out_rsp_o.status !== want.status ||
            out_rsp_o.seq_number !== want.seq_number ||
            out_rsp_o.command_word !== want.command_word ||
            out_rsp_o.payload_count !== want.payload_count) begin
          note_error($sformatf("mismatch\n  exp %s\n  got %s", rsp_text(want),
                               rsp_text(out_rsp_o)));
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  task automatic stage_byte(input int l, input logic [7:0] b);
    if (l == 0) stage0_q.push_back(b);
    else stage1_q.push_back(b);
  endtask

  // Interleave both links' staged bytes into the send queue
  task automatic merge_stages();
    int      pick;
    in_req_t r;
    while (stage0_q.size() + stage1_q.size() > 0) begin
      if (stage0_q.size() == 0) pick = 1;
      else if (stage1_q.size() == 0) pick = 0;
      else pick = $urandom_range(1);
      r.link    = pick[0];
      r.rx_byte = pick ? stage1_q.pop_front() : stage0_q.pop_front();
      rx_byte_q.push_back(r);
      items_made++;
    end
  endtask

  // Zero, 0xFF and 0x01 show up far more often than uniform
  function automatic logic [7:0] spicy_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    if (r == 2) return 8'h01;
    return 8'($urandom_range(255));
  endfunction

  // COBS-encode frame_dec_q into frame_enc_q
  task automatic stuff_frame();
    int code_pos;
    int code;
    frame_enc_q.delete();
    code_pos = 0;
    code = 1;
    frame_enc_q.push_back(8'h00);
    foreach (frame_dec_q[i]) begin
      if (frame_dec_q[i] == 8'h00) begin
        frame_enc_q[code_pos] = code[7:0];
        code_pos = frame_enc_q.size();
        frame_enc_q.push_back(8'h00);
        code = 1;
      end else begin
        frame_enc_q.push_back(frame_dec_q[i]);
        code++;
        if (code == 255) begin
          frame_enc_q[code_pos] = code[7:0];
          code_pos = frame_enc_q.size();
          frame_enc_q.push_back(8'h00);
          code = 1;
        end
      end
    end
    frame_enc_q[code_pos] = code[7:0];
  endtask

  task automatic stage_encoded(input int l);
    foreach (frame_enc_q[i]) stage_byte(l, frame_enc_q[i]);
    stage_byte(l, DELIM);
  endtask

  // Append CRC in the current byte order, optionally damage, then encode and stage
  task automatic seal_frame(input int l, input int shape);
    logic [15:0] crc;
    int          idx;
    int          drop;
    crc = CRC_INIT;
    foreach (frame_dec_q[i]) crc = crc16_ccitt_step(crc, frame_dec_q[i]);
    if (cfg_big_endian) begin
      frame_dec_q.push_back(crc[15:8]);
      frame_dec_q.push_back(crc[7:0]);
    end else begin
      frame_dec_q.push_back(crc[7:0]);
      frame_dec_q.push_back(crc[15:8]);
    end
    if (shape == FK_BAD_CRC) begin
      idx = $urandom_range(frame_dec_q.size() - 1);
      frame_dec_q[idx] = frame_dec_q[idx] ^ (8'h01 << $urandom_range(7));
    end
    stuff_frame();
    if (shape == FK_TRUNC) begin
      drop = $urandom_range(3, 1);
      repeat (drop) void'(frame_enc_q.pop_back());
    end
    stage_encoded(l);
  endtask

  task automatic build_frame(input int l, input int shape);
    int len;
    frame_dec_q.delete();
    case (shape)
      FK_SHORT: begin
        len = $urandom_range(5, 1);
        repeat (len) frame_dec_q.push_back(spicy_byte());
        stuff_frame();
        stage_encoded(l);
      end
      FK_NOISE: begin
        len = $urandom_range(10, 1);
        repeat (len) stage_byte(l, 8'($urandom_range(255)));
        stage_byte(l, DELIM);
      end
      FK_RUN: begin
        // long zero-free payload forces full 254-byte blocks
        repeat (4) frame_dec_q.push_back(spicy_byte());
        len = $urandom_range(300, 250);
        repeat (len) frame_dec_q.push_back(8'($urandom_range(255, 1)));
        seal_frame(l, FK_GOOD);
      end
      default: begin
        repeat (4) frame_dec_q.push_back(spicy_byte());
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16);
        repeat (len) frame_dec_q.push_back(spicy_byte());
        seal_frame(l, shape);
      end
    endcase
  endtask

  function automatic int pick_shape();
    int r;
    r = $urandom_range(99);
    if (r < 55) return FK_GOOD;
    if (r < 65) return FK_BAD_CRC;
    if (r < 75) return FK_TRUNC;
    if (r < 85) return FK_SHORT;
    if (r < 97) return FK_NOISE;
    return FK_RUN;
  endfunction

  task automatic random_phase(input int n_items);
    int start;
    start = items_made;
    while (items_made - start < n_items) begin
      if ($urandom_range(3) != 0) build_frame(0, pick_shape());
      if ($urandom_range(3) != 0) build_frame(1, pick_shape());
      merge_stages();
    end
  endtask

  // Let everything sent come out, then wait for bytes that produce nothing
  task automatic drain_and_settle();
    while (rx_byte_q.size() != 0 || in_valid_i || decoded_out_q.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_byte_order(input logic big_endian);
    @(posedge clk_i);
    cfg_we_i       <= 1'b1;
    cfg_wdata_i    <= big_endian;
    cfg_big_endian = big_endian;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- main sequence

  initial begin
    lane_clear(0);
    lane_clear(1);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    write_byte_order(1'b0);

    // Directed: empty frame, one-byte frame, truncated block
    stage_byte(0, DELIM);
    stage_byte(0, 8'h02); stage_byte(0, 8'h5A); stage_byte(0, DELIM);
    stage_byte(0, 8'h05); stage_byte(0, 8'h11); stage_byte(0, 8'h22); stage_byte(0, DELIM);
    merge_stages();
    // Directed: good frame with zero and 0xFF header/payload bytes on link 1
    frame_dec_q = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h00};
    seal_frame(1, FK_GOOD);
    merge_stages();
    drain_and_settle();

    // Big endian, free-running flow first, then with stalls
    write_byte_order(1'b1);
    steady_flow = 1'b1;
    random_phase(150);
    drain_and_settle();
    steady_flow = 1'b0;
    random_phase(350);
    drain_and_settle();

    // Little endian: encoded length right at the limit and just past it
    write_byte_order(1'b0);
    repeat (MAX_ENC) stage_byte(0, 8'($urandom_range(255, 1)));
    stage_byte(0, DELIM);
    repeat (MAX_ENC + 4) stage_byte(1, 8'($urandom_range(255, 1)));
    stage_byte(1, DELIM);
    merge_stages();
    random_phase(150);
    drain_and_settle();

    write_byte_order(1'b1);
    random_phase(200);
    drain_and_settle();

    write_byte_order(1'b0);
    random_phase(150);
    drain_and_settle();
    repeat (20) @(posedge clk_i);

    if (decoded_out_q.size() != 0)
      note_error($sformatf("%0d expected results never arrived", decoded_out_q.size()));
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
